### src/stg_pkg.sv
// ============================================================================
// stg_pkg: shared types and constants of the sine tone generator
// format and opcode codes, register indexes, stage payload structs and the
// quarter-wave sine entry function used to build the rom at elaboration
// ============================================================================
`default_nettype none

package stg_pkg;

    // channel limits: never more than eight lanes per frame
    localparam int MAX_CHANNELS = 8;
    localparam int OUT_LIMIT    = 8;
    localparam int CHAN_LIMIT   = (MAX_CHANNELS < OUT_LIMIT) ? MAX_CHANNELS : OUT_LIMIT;

    // pi/2 in q30
    localparam logic [63:0] PIHALF_Q30 = 64'd1686629713;
    localparam logic signed [64:0] ONE_Q30 = 65'sd1073741824;

    // request codes
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_SEEK  = 1'b1;

    // register indexes
    localparam logic [1:0] CFG_PHASE_STEP    = 2'd0;
    localparam logic [1:0] CFG_SAMPLE_FORMAT = 2'd1;
    localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd2;

    typedef enum logic [1:0] {
        FMT_S8  = 2'd0,
        FMT_U8  = 2'd1,
        FMT_S16 = 2'd2,
        FMT_U16 = 2'd3
    } t_fmt;

    localparam logic [14:0] AMP_8  = 15'd127;
    localparam logic [14:0] AMP_16 = 15'd32767;
    localparam logic [15:0] MID_8  = 16'h0080;
    localparam logic [15:0] MID_16 = 16'h8000;
    localparam logic [15:0] MASK_8 = 16'h00ff;

    // phase stage to scaler
    typedef struct packed {
        logic        valid;
        logic        neg;
        logic [31:0] position;
    } t_tone;

    // scaler to frame output
    typedef struct packed {
        logic        valid;
        logic [15:0] code;
        logic [31:0] position;
    } t_frame;

    // sin(k/N * pi/2) in q30, taylor series to x^15 with truncating shifts
    function automatic logic [30:0] quarter_sine(input int unsigned k, input int addr_bits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        t;
        logic signed [64:0] acc;
        x   = (64'(k) * PIHALF_Q30) >> addr_bits;
        x2  = (x * x) >> 30;
        t   = x;
        acc = $signed({1'b0, x});
        t   = ((t * x2) >> 30) / 64'd6;
        acc = acc - $signed({1'b0, t});
        t   = ((t * x2) >> 30) / 64'd20;
        acc = acc + $signed({1'b0, t});
        t   = ((t * x2) >> 30) / 64'd42;
        acc = acc - $signed({1'b0, t});
        t   = ((t * x2) >> 30) / 64'd72;
        acc = acc + $signed({1'b0, t});
        t   = ((t * x2) >> 30) / 64'd110;
        acc = acc - $signed({1'b0, t});
        t   = ((t * x2) >> 30) / 64'd156;
        acc = acc + $signed({1'b0, t});
        t   = ((t * x2) >> 30) / 64'd210;
        acc = acc - $signed({1'b0, t});
        if (acc < 65'sd0) begin
            acc = 65'sd0;
        end
        if (acc > ONE_Q30) begin
            acc = ONE_Q30;
        end
        return acc[30:0];
    endfunction

endpackage

`default_nettype wire

### src/sine_tone_generator_unit.sv
// ============================================================================
// sine_tone_generator_unit: direct digital synthesis sine oscillator
// a phase accumulator indexes a quarter-wave table; each frame request
// gives one sample per channel, a seek request moves position and phase
// ============================================================================
//
//  channel   direction  handshake              beat carries
//  -------   ---------  ---------------------  ---------------------------------
//  request   in         i_valid / o_stall      i_opcode, i_seek_position
//  sample    out        o_valid / i_stall      o_sample, o_channel, o_last,
//                                              o_frame_position
//  config    in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
//  a frame request gives max(1, channel count) beats, capped at eight, one a
//  cycle while i_stall is low; the next frame loads as the last beat leaves
//  a frame's first beat passes the request reg, phase stage, rom read,
//  multiply and output register in that order
//  a seek moves position and phase as it leaves the request reg, no beat
//  synchronous active-low reset clears phase, position and all valids; the
//  table is a constant rom, so there is no clearing pass
//  a stall on the sample side holds the output beat and fills the stages
//  behind it before o_stall rises
// ============================================================================
`default_nettype none

module sine_tone_generator_unit #(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_opcode,
    input  wire logic [31:0] i_seek_position,
    // sample channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_sample,
    output logic [2:0]       o_channel,
    output logic             o_last,
    output logic [31:0]      o_frame_position,
    // register writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    // configuration registers
    logic [31:0]    r_phase_step;
    stg_pkg::t_fmt  r_sample_format;
    logic [3:0]     r_channel_count;

    // stage links
    logic                       in_ready;
    logic                       tone_ready;
    logic                       frame_ready;
    stg_pkg::t_tone             tone;
    stg_pkg::t_frame            frame;
    logic [TABLE_ADDR_BITS:0]   rom_addr;
    logic [30:0]                rom_data;

    // writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step    <= 32'd0;
            r_sample_format <= stg_pkg::FMT_S16;
            r_channel_count <= 4'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                stg_pkg::CFG_PHASE_STEP: begin
                    r_phase_step <= i_cfg_data;
                end
                stg_pkg::CFG_SAMPLE_FORMAT: begin
                    r_sample_format <= stg_pkg::t_fmt'(i_cfg_data[1:0]);
                end
                stg_pkg::CFG_CHANNEL_COUNT: begin
                    r_channel_count <= i_cfg_data[3:0];
                end
                default: begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    // request register, phase accumulator and frame counter
    stg_phase_unit #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_phase (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_opcode        (i_opcode),
        .i_seek_position (i_seek_position),
        .i_phase_step    (r_phase_step),
        .i_tone_ready    (tone_ready),
        .o_in_ready      (in_ready),
        .o_tone          (tone),
        .o_rom_addr      (rom_addr)
    );

    assign o_stall = !in_ready;

    // table read advances together with the rom stage side data
    stg_sine_rom #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_en   (tone_ready),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

    // amplitude multiply, rounding, sign and offset
    stg_amp_scale u_scale (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tone        (tone),
        .i_tab         (rom_data),
        .i_fmt         (r_sample_format),
        .i_frame_ready (frame_ready),
        .o_tone_ready  (tone_ready),
        .o_frame       (frame)
    );

    // output register, one beat per channel
    stg_frame_out u_out (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_frame          (frame),
        .i_channel_count  (r_channel_count),
        .i_stall          (i_stall),
        .o_frame_ready    (frame_ready),
        .o_valid          (o_valid),
        .o_sample         (o_sample),
        .o_channel        (o_channel),
        .o_last           (o_last),
        .o_frame_position (o_frame_position)
    );

endmodule

`default_nettype wire

### src/stg_phase_unit.sv
// ============================================================================
// stg_phase_unit: request register, phase accumulator and frame counter
// turns each frame request into a rom address, sign and frame number
// ============================================================================
`default_nettype none

module stg_phase_unit #(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire logic                       i_opcode,
    input  wire logic [31:0]                i_seek_position,
    input  wire logic [31:0]                i_phase_step,
    input  wire logic                       i_tone_ready,
    output logic                            o_in_ready,
    output stg_pkg::t_tone                  o_tone,
    output logic [TABLE_ADDR_BITS:0]        o_rom_addr
);

    localparam int AW = TABLE_ADDR_BITS + 1;
    localparam int N  = 1 << TABLE_ADDR_BITS;

    logic                   r_v0;
    logic                   r_op0;
    logic [31:0]            r_pos0;
    logic [PHASE_BITS-1:0]  r_phase;
    logic [31:0]            r_frame;
    logic                   r_v1;
    logic                   r_neg1;
    logic [31:0]            r_pos1;
    logic [AW-1:0]          r_addr1;

    logic                   ready1;
    logic                   move0;
    logic [63:0]            seek_prod;
    logic [PHASE_BITS-1:0]  step_pb;
    logic [AW-1:0]          idx;
    logic [AW-1:0]          n_addr;

    assign ready1     = !r_v1 || i_tone_ready;
    assign o_in_ready = !r_v0 || ready1;
    assign move0      = r_v0 && ready1;

    assign seek_prod = 64'(r_pos0) * 64'(i_phase_step);
    assign step_pb   = PHASE_BITS'(i_phase_step);

    // quadrant 1 and 3 read the table mirrored
    assign idx    = {1'b0, r_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS]};
    assign n_addr = r_phase[PHASE_BITS-2] ? (AW'(N) - idx) : idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            r_phase <= '0;
            r_frame <= '0;
        end else begin
            if (i_valid && o_in_ready) begin
                r_v0 <= 1'b1;
            end else if (ready1) begin
                r_v0 <= 1'b0;
            end
            if (ready1) begin
                r_v1 <= move0 && (r_op0 == stg_pkg::OP_FRAME);
            end
            if (move0) begin
                if (r_op0 == stg_pkg::OP_SEEK) begin
                    r_phase <= seek_prod[PHASE_BITS-1:0];
                    r_frame <= r_pos0;
                end else begin
                    r_phase <= r_phase + step_pb;
                    r_frame <= r_frame + 32'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_in_ready) begin
            r_op0  <= i_opcode;
            r_pos0 <= i_seek_position;
        end
        if (ready1) begin
            r_neg1  <= r_phase[PHASE_BITS-1];
            r_pos1  <= r_frame;
            r_addr1 <= n_addr;
        end
    end

    assign o_tone.valid    = r_v1;
    assign o_tone.neg      = r_neg1;
    assign o_tone.position = r_pos1;
    assign o_rom_addr      = r_addr1;

endmodule

`default_nettype wire

### src/stg_sine_rom.sv
// ============================================================================
// stg_sine_rom: quarter-wave sine table, q30, registered read
// ============================================================================
`default_nettype none

module stg_sine_rom #(
    parameter int TABLE_ADDR_BITS = 10
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire logic [TABLE_ADDR_BITS:0] i_addr,
    output logic [30:0]                 o_data
);

    localparam int N = 1 << TABLE_ADDR_BITS;

    logic [30:0] tab_val [0:N];
    logic [30:0] r_data;

    for (genvar k = 0; k <= N; k++) begin : g_tab
        localparam logic [30:0] K_VAL = stg_pkg::quarter_sine(k, TABLE_ADDR_BITS);
        assign tab_val[k] = K_VAL;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= tab_val[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

### src/stg_amp_scale.sv
// ============================================================================
// stg_amp_scale: scales the table value to full scale and forms the code
// holds the rom stage side data and the product register
// ============================================================================
`default_nettype none

module stg_amp_scale (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire stg_pkg::t_tone  i_tone,
    input  wire logic [30:0]     i_tab,
    input  wire stg_pkg::t_fmt   i_fmt,
    input  wire logic            i_frame_ready,
    output logic                 o_tone_ready,
    output stg_pkg::t_frame      o_frame
);

    logic        r_v2;
    logic        r_neg2;
    logic [31:0] r_pos2;
    logic        r_v3;
    logic        r_neg3;
    logic [31:0] r_pos3;
    logic [45:0] r_prod3;

    logic        ready3;
    logic        is_8bit;
    logic        is_unsigned;
    logic [14:0] amp;
    logic [46:0] rounded;
    logic [15:0] mag;
    logic [15:0] sv;
    logic [15:0] code;

    assign ready3       = !r_v3 || i_frame_ready;
    assign o_tone_ready = !r_v2 || ready3;

    assign is_8bit     = (i_fmt == stg_pkg::FMT_S8) || (i_fmt == stg_pkg::FMT_U8);
    assign is_unsigned = (i_fmt == stg_pkg::FMT_U8) || (i_fmt == stg_pkg::FMT_U16);
    assign amp         = is_8bit ? stg_pkg::AMP_8 : stg_pkg::AMP_16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (o_tone_ready) begin
                r_v2 <= i_tone.valid;
            end
            if (ready3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tone_ready) begin
            r_neg2 <= i_tone.neg;
            r_pos2 <= i_tone.position;
        end
        if (ready3) begin
            r_neg3  <= r_neg2;
            r_pos3  <= r_pos2;
            r_prod3 <= 46'(i_tab) * 46'(amp);
        end
    end

    // round half up, then sign and offset for the format
    always_comb begin
        rounded = {1'b0, r_prod3} + 47'(64'd1 << 29);
        mag     = rounded[45:30];
        sv      = r_neg3 ? (16'd0 - mag) : mag;
        if (is_unsigned) begin
            sv = sv + (is_8bit ? stg_pkg::MID_8 : stg_pkg::MID_16);
        end
        code = is_8bit ? (sv & stg_pkg::MASK_8) : sv;
    end

    assign o_frame.valid    = r_v3;
    assign o_frame.code     = code;
    assign o_frame.position = r_pos3;

endmodule

`default_nettype wire

### src/stg_frame_out.sv
// ============================================================================
// stg_frame_out: output register that repeats one frame over its channels
// ============================================================================
`default_nettype none

module stg_frame_out (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire stg_pkg::t_frame i_frame,
    input  wire logic [3:0]      i_channel_count,
    input  wire logic            i_stall,
    output logic                 o_frame_ready,
    output logic                 o_valid,
    output logic [15:0]          o_sample,
    output logic [2:0]           o_channel,
    output logic                 o_last,
    output logic [31:0]          o_frame_position
);

    logic        r_v;
    logic [2:0]  r_ch;
    logic [2:0]  r_last_idx;
    logic [15:0] r_code;
    logic [31:0] r_pos;

    logic        beat;
    logic        is_last;
    logic [3:0]  cnt_m1;
    logic [2:0]  n_last_idx;

    assign is_last       = (r_ch == r_last_idx);
    assign beat          = r_v && !i_stall;
    assign o_frame_ready = !r_v || (beat && is_last);

    // zero counts as one channel, the top is capped
    assign cnt_m1 = i_channel_count - 4'd1;
    always_comb begin
        if (i_channel_count == 4'd0) begin
            n_last_idx = 3'd0;
        end else if (i_channel_count > 4'(stg_pkg::CHAN_LIMIT)) begin
            n_last_idx = 3'(stg_pkg::CHAN_LIMIT - 1);
        end else begin
            n_last_idx = cnt_m1[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= 1'b0;
            r_ch <= 3'd0;
        end else begin
            if (o_frame_ready && i_frame.valid) begin
                r_v  <= 1'b1;
                r_ch <= 3'd0;
            end else if (beat && is_last) begin
                r_v  <= 1'b0;
                r_ch <= 3'd0;
            end else if (beat) begin
                r_ch <= r_ch + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_frame_ready && i_frame.valid) begin
            r_code     <= i_frame.code;
            r_pos      <= i_frame.position;
            r_last_idx <= n_last_idx;
        end
    end

    assign o_valid          = r_v;
    assign o_sample         = r_code;
    assign o_channel        = r_ch;
    assign o_last           = is_last;
    assign o_frame_position = r_pos;

endmodule

`default_nettype wire

### src/stg_checker.sv
// ============================================================================
// stg_checker: port-level checks of the sample channel
// bound to the top level
// ============================================================================
`default_nettype none

module stg_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [15:0] o_sample,
    input wire logic [2:0]  o_channel,
    input wire logic        o_last,
    input wire logic [31:0] o_frame_position
);

    // a stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sample) && $stable(o_channel)
            && $stable(o_last) && $stable(o_frame_position))
        else $error("stalled sample beat changed");

    // channels of one frame share sample and position and count up
    a_next_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=> o_valid
            && (o_channel == 3'($past(o_channel) + 3'd1))
            && $stable(o_sample) && $stable(o_frame_position))
        else $error("frame channels out of step");

    // a new frame starts at channel zero
    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_last |=> !o_valid || (o_channel == 3'd0))
        else $error("frame did not start at channel zero");

    // nothing leaves right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("beat shown after reset");

endmodule

bind sine_tone_generator_unit stg_checker u_stg_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_sample         (o_sample),
    .o_channel        (o_channel),
    .o_last           (o_last),
    .o_frame_position (o_frame_position)
);

`default_nettype wire
